[rtl/sfa_pkg.sv]
// Shared types, codes and a helper function of the sensor frame assembler.
// No dependencies; the top level refers to it by scoped names.
package sfa_pkg;

    localparam int NUM_SLOTS      = 8;
    localparam int SLOT_W         = 3;
    localparam int EXTERNAL_SLOTS = 5;
    localparam int FRAME_MAX      = 220;
    localparam int FIRST_EXT_SLOT = 3;

    // Input operations.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BATTERY_ID  = 2'd0;
    localparam logic [1:0] CFG_VOLTAGE_ID  = 2'd1;
    localparam logic [1:0] CFG_CURRENT_ID  = 2'd2;
    localparam logic [1:0] CFG_EXT_BASE_ID = 2'd3;

    // Fixed slot positions.
    localparam int SLOT_BATTERY = 0;
    localparam int SLOT_VOLTAGE = 1;
    localparam int SLOT_CURRENT = 2;

    // Frame sections.
    localparam logic [2:0] SEC_ID   = 3'd0;
    localparam logic [2:0] SEC_TIME = 3'd1;
    localparam logic [2:0] SEC_MASK = 3'd2;
    localparam logic [2:0] SEC_LEN  = 3'd3;
    localparam logic [2:0] SEC_DATA = 3'd4;
    localparam logic [2:0] SEC_DONE = 3'd5;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } slot_pick_t;

    // Lowest set bit of mask at or above position from.
    function automatic slot_pick_t first_set(input logic [NUM_SLOTS-1:0] mask,
                                             input logic [SLOT_W-1:0] from);
        logic [NUM_SLOTS-1:0] masked;
        slot_pick_t           pick;
        masked     = mask & ({NUM_SLOTS{1'b1}} << from);
        pick.found = |masked;
        pick.idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                pick.idx = SLOT_W'(i);
            end
        end
        return pick;
    endfunction

endpackage

[rtl/sfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/sensor_frame_assembler.sv]
// Top level of the sensor frame assembler: slot bookkeeping, frame sequencer, config port.
// Depends on sfa_pkg and sfa_ram.
//
// Sensor bytes are sorted into eight slots kept in one slot memory of 8 x 2^clog2(SLOT_BYTES)
// bytes; a frame is then pulled out one byte per item. A load writes its matching slots one
// at a time, lowest first, because the slot memory has a single write port; a load that
// matches nothing is dropped. A pull reads the slot memory as it is accepted and forms the
// frame byte from the registered read data; the byte may then wait in the output register.
// Further items stall while a load or pull is in progress. The slot memory is never cleared:
// only bytes below a slot's fill count are ever read, so it is usable straight out of reset.
module sensor_frame_assembler #(
    parameter int SLOT_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  sensor_id,
    input  logic [7:0]  data_byte,
    input  logic [4:0]  regs_per_channel,
    input  logic [7:0]  message_id,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int NS     = sfa_pkg::NUM_SLOTS;
    localparam int SW     = sfa_pkg::SLOT_W;
    localparam int ROW_W  = $clog2(SLOT_BYTES);
    localparam int FILL_W = $clog2(SLOT_BYTES + 1);
    localparam int ADDR_W = SW + ROW_W;
    localparam int DEPTH  = NS * (2 ** ROW_W);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOT_BYTES);
    localparam logic [7:0]        COUNT_MAX = 8'(sfa_pkg::FRAME_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_PULL = 2'd2;

    logic [1:0]        state_reg,  state_next;
    logic              busy_reg,   busy_next;
    logic [2:0]        sec_reg,    sec_next;
    logic [SW-1:0]     slot_reg,   slot_next;
    logic [ROW_W-1:0]  byte_reg,   byte_next;
    logic [7:0]        count_reg,  count_next;
    logic [7:0]        msg_reg,    msg_next;
    logic [31:0]       time_reg,   time_next;
    logic [NS-1:0]     mask_reg,   mask_next;
    logic [NS-1:0]     pend_reg,   pend_next;
    logic [7:0]        ld_data_reg, ld_data_next;
    logic [4:0]        ld_regs_reg, ld_regs_next;
    logic [FILL_W-1:0] fill_reg [NS];
    logic [FILL_W-1:0] fill_next [NS];
    logic [4:0]        regs_reg [NS];
    logic [4:0]        regs_next [NS];
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg,  out_byte_next;
    logic              out_last_reg,  out_last_next;
    logic [7:0]        battery_id_reg, voltage_id_reg, current_id_reg, ext_base_reg;

    logic              accept;
    logic              out_free;
    logic              emit;
    logic [NS-1:0]     match;
    logic [NS-1:0]     fill_nz;
    sfa_pkg::slot_pick_t ld_pick;
    logic [SW-1:0]     ld_slot;
    logic [FILL_W-1:0] ld_fill;
    logic              ld_room;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Pull datapath intermediates.
    logic [7:0]        pull_byte;
    logic [2:0]        sec_a, sec_b, sec_c;
    logic [SW-1:0]     slot_a, slot_b, slot_c;
    logic [ROW_W-1:0]  byte_a, byte_b;
    logic [ROW_W:0]    byte_inc;
    logic [7:0]        count_inc;
    logic              pull_last;
    sfa_pkg::slot_pick_t pick_len, pick_data;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_PULL) && out_free;
    assign out_valid = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;
    assign cfg_ready  = 1'b1;

    // Slot selection by sensor id; one id may select several slots.
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (k == sfa_pkg::SLOT_BATTERY)
            begin
                match[k] = (sensor_id == battery_id_reg);
            end
            else if (k == sfa_pkg::SLOT_VOLTAGE)
            begin
                match[k] = (sensor_id == voltage_id_reg);
            end
            else if (k == sfa_pkg::SLOT_CURRENT)
            begin
                match[k] = (sensor_id == current_id_reg);
            end
            else if (k - sfa_pkg::FIRST_EXT_SLOT < sfa_pkg::EXTERNAL_SLOTS)
            begin
                match[k] = (sensor_id ==
                            8'(ext_base_reg + 8'(k - sfa_pkg::FIRST_EXT_SLOT)));
            end
            else
            begin
                match[k] = 1'b0;
            end
            fill_nz[k] = (fill_reg[k] != '0);
        end
    end

    // Load walk: one matching slot per cycle, lowest first.
    assign ld_pick = sfa_pkg::first_set(pend_reg, '0);
    assign ld_slot = ld_pick.idx;
    assign ld_fill = fill_reg[ld_slot];
    assign ld_room = (ld_fill < FILL_FULL);
    assign wr_en   = (state_reg == ST_LOAD) && ld_room;
    assign wr_addr = {ld_slot, ld_fill[ROW_W-1:0]};

    // The data byte for a pull is fetched as the pull is accepted.
    assign rd_en   = accept && (operation == sfa_pkg::OP_PULL) && busy_reg;
    assign rd_addr = {slot_reg, byte_reg};

    sfa_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ld_data_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Frame byte and cursor advance for one pull.
    always_comb
    begin
        pull_byte = '0;
        sec_a     = sec_reg;
        slot_a    = slot_reg;
        byte_a    = byte_reg;
        byte_inc  = (ROW_W + 1)'(byte_reg) + 1'b1;
        case (sec_reg)
            sfa_pkg::SEC_ID:
            begin
                pull_byte = msg_reg;
                sec_a     = sfa_pkg::SEC_TIME;
                byte_a    = '0;
            end
            sfa_pkg::SEC_TIME:
            begin
                case (byte_reg[1:0])
                    2'd0:    pull_byte = time_reg[31:24];
                    2'd1:    pull_byte = time_reg[23:16];
                    2'd2:    pull_byte = time_reg[15:8];
                    default: pull_byte = time_reg[7:0];
                endcase
                if (byte_reg[1:0] == 2'd3)
                begin
                    sec_a  = sfa_pkg::SEC_MASK;
                    byte_a = '0;
                end
                else
                begin
                    byte_a = byte_inc[ROW_W-1:0];
                end
            end
            sfa_pkg::SEC_MASK:
            begin
                pull_byte = mask_reg;
                sec_a     = sfa_pkg::SEC_LEN;
                slot_a    = '0;
            end
            sfa_pkg::SEC_LEN:
            begin
                pull_byte = {3'b000, regs_reg[slot_reg]};
                if (slot_reg == SW'(NS - 1))
                begin
                    sec_a  = sfa_pkg::SEC_DATA;
                    slot_a = '0;
                    byte_a = '0;
                end
                else
                begin
                    slot_a = slot_reg + 1'b1;
                end
            end
            sfa_pkg::SEC_DATA:
            begin
                pull_byte = rd_data;
                if (byte_inc >= (ROW_W + 1)'(fill_reg[slot_reg]))
                begin
                    byte_a = '0;
                    if (slot_reg == SW'(NS - 1))
                    begin
                        sec_a  = sfa_pkg::SEC_DONE;
                        slot_a = '0;
                    end
                    else
                    begin
                        slot_a = slot_reg + 1'b1;
                    end
                end
                else
                begin
                    byte_a = byte_inc[ROW_W-1:0];
                end
            end
            default:
            begin
                pull_byte = '0;
            end
        endcase

        // Skip slots that hold nothing, then sections that are used up.
        sec_b    = sec_a;
        slot_b   = slot_a;
        byte_b   = byte_a;
        pick_len = sfa_pkg::first_set(mask_reg, slot_a);
        if (sec_a == sfa_pkg::SEC_LEN)
        begin
            if (pick_len.found)
            begin
                slot_b = pick_len.idx;
            end
            else
            begin
                sec_b  = sfa_pkg::SEC_DATA;
                slot_b = '0;
                byte_b = '0;
            end
        end
        sec_c     = sec_b;
        slot_c    = slot_b;
        pick_data = sfa_pkg::first_set(mask_reg, slot_b);
        if (sec_b == sfa_pkg::SEC_DATA)
        begin
            if (pick_data.found)
            begin
                slot_c = pick_data.idx;
            end
            else
            begin
                sec_c  = sfa_pkg::SEC_DONE;
                slot_c = '0;
            end
        end
        count_inc = count_reg + 1'b1;
        pull_last = (sec_c == sfa_pkg::SEC_DONE) || (count_inc >= COUNT_MAX);
    end

    // Control and bookkeeping.
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        sec_next       = sec_reg;
        slot_next      = slot_reg;
        byte_next      = byte_reg;
        count_next     = count_reg;
        msg_next       = msg_reg;
        time_next      = time_reg;
        mask_next      = mask_reg;
        pend_next      = pend_reg;
        ld_data_next   = ld_data_reg;
        ld_regs_next   = ld_regs_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        for (int k = 0; k < NS; k++)
        begin
            fill_next[k] = fill_reg[k];
            regs_next[k] = regs_reg[k];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        sfa_pkg::OP_LOAD:
                        begin
                            if (!busy_reg && (match != '0))
                            begin
                                pend_next    = match;
                                ld_data_next = data_byte;
                                ld_regs_next = regs_per_channel;
                                state_next   = ST_LOAD;
                            end
                        end
                        sfa_pkg::OP_START:
                        begin
                            msg_next   = message_id;
                            time_next  = timestamp;
                            mask_next  = fill_nz;
                            busy_next  = 1'b1;
                            sec_next   = sfa_pkg::SEC_ID;
                            slot_next  = '0;
                            byte_next  = '0;
                            count_next = '0;
                        end
                        sfa_pkg::OP_PULL:
                        begin
                            if (busy_reg)
                            begin
                                state_next = ST_PULL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                regs_next[ld_slot] = ld_regs_reg;
                if (ld_room)
                begin
                    fill_next[ld_slot] = ld_fill + 1'b1;
                end
                pend_next = pend_reg & ~(NS'(1) << ld_slot);
                if ((pend_reg & ~(NS'(1) << ld_slot)) == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PULL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pull_byte;
                    out_last_next  = pull_last;
                    state_next     = ST_IDLE;
                    if (pull_last)
                    begin
                        busy_next  = 1'b0;
                        sec_next   = sfa_pkg::SEC_ID;
                        slot_next  = '0;
                        byte_next  = '0;
                        count_next = '0;
                        for (int k = 0; k < NS; k++)
                        begin
                            fill_next[k] = '0;
                            regs_next[k] = '0;
                        end
                    end
                    else
                    begin
                        sec_next   = sec_c;
                        slot_next  = slot_c;
                        byte_next  = byte_b;
                        count_next = count_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            sec_reg       <= sfa_pkg::SEC_ID;
            slot_reg      <= '0;
            byte_reg      <= '0;
            count_reg     <= '0;
            msg_reg       <= '0;
            time_reg      <= '0;
            mask_reg      <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                fill_reg[k] <= '0;
                regs_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            sec_reg       <= sec_next;
            slot_reg      <= slot_next;
            byte_reg      <= byte_next;
            count_reg     <= count_next;
            msg_reg       <= msg_next;
            time_reg      <= time_next;
            mask_reg      <= mask_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < NS; k++)
            begin
                fill_reg[k] <= fill_next[k];
                regs_reg[k] <= regs_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_data_reg  <= ld_data_next;
        ld_regs_reg  <= ld_regs_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            battery_id_reg <= 8'd1;
            voltage_id_reg <= 8'd2;
            current_id_reg <= 8'd3;
            ext_base_reg   <= 8'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfa_pkg::CFG_BATTERY_ID:  battery_id_reg <= cfg_data;
                sfa_pkg::CFG_VOLTAGE_ID:  voltage_id_reg <= cfg_data;
                sfa_pkg::CFG_CURRENT_ID:  current_id_reg <= cfg_data;
                sfa_pkg::CFG_EXT_BASE_ID: ext_base_reg   <= cfg_data;
                default:                  ext_base_reg   <= ext_base_reg;
            endcase
        end
    end

    // Slot memory writes only happen outside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !busy_reg)
        else $error("slot load walk running during a frame");

    // The final byte of a frame leaves every slot empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pull_last) |=> (!busy_reg && (fill_nz == '0)))
        else $error("slots not cleared after final frame byte");

    // A frame in progress never parks on the finished section.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (sec_reg != sfa_pkg::SEC_DONE))
        else $error("frame busy with cursor past the end");

    // A pull only reaches the output stage while a frame is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULL) |-> busy_reg)
        else $error("pull in progress without an open frame");

endmodule
